FILE: rtl/core/rs_pkg.sv
// shared constants, command and status types, and the random step for the reservoir sampler
package rs_pkg;

    localparam int RAND_W     = 31;
    localparam int COUNT_W    = 32;
    localparam int SIZE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int DIV_STEPS  = RAND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [RAND_W-1:0]     RAND_RANGE = 31'h7FFF_FFFF;
    localparam logic [COUNT_W-1:0]    COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [SIZE_W-1:0]     SIZE_RESET = 5'd16;
    localparam logic [RAND_W-1:0]     SEED_RESET = 31'd1;

    localparam logic [CFG_IDX_W-1:0]  REG_SAMPLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_RANDOM_SEED = 2'd1;

    typedef struct packed {
        logic offer;       // take an offered word
        logic dump_start;  // take a dump word and restart the stream
        logic div_start;   // launch the divider
        logic div_sel_t;   // 0: range / n, 1: draw / n
        logic bound_load;  // capture the rejection bound
        logic draw_step;   // advance the lfsr for one try
        logic slot_write;  // replace the drawn slot
        logic dump_emit;   // load one slot into the output register
        logic cfg_write;   // register write
    } t_rs_cmd;

    typedef struct packed {
        logic in_dump;
        logic dump_empty;
        logic filling;
        logic div_done;
        logic t_ok;
        logic out_free;
        logic dump_last;
    } t_rs_sts;

    // fibonacci lfsr, taps 31 and 28
    function automatic logic [RAND_W-1:0] lfsr_next(input logic [RAND_W-1:0] s);
        logic [RAND_W-1:0] n;
        n = {s[RAND_W-2:0], s[30] ^ s[27]};
        if (n == '0) begin
            n = RAND_W'(1);
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/rs_ifs.sv
// valid/ready channel interfaces of the reservoir sampler
interface rs_in_if #(
    parameter int VALUE_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface rs_out_if #(
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 4
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic [IDX_W-1:0]             slot_index;
    logic                         last;

    modport source (output valid, output sample_value, output slot_index, output last,
                    input ready);
    modport sink   (input valid, input sample_value, input slot_index, input last,
                    output ready);
endinterface

interface rs_cfg_if import rs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rs_div.sv
// restoring divider, one remainder bit per cycle, remainder only
module rs_div import rs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAND_W-1:0] i_dividend,
    input  logic [RAND_W-1:0] i_divisor,
    output logic              o_done,
    output logic [RAND_W-1:0] o_rem
);

    logic                 r_busy,  n_busy;
    logic                 r_done,  n_done;
    logic [DIV_CNT_W-1:0] r_cnt,   n_cnt;
    logic [RAND_W-1:0]    r_dvd,   n_dvd;
    logic [RAND_W-1:0]    r_rem,   n_rem;
    logic [RAND_W-1:0]    r_dsr,   n_dsr;
    logic [RAND_W:0]      w_part;
    logic [RAND_W:0]      w_diff;

    assign w_part = {r_rem, r_dvd[RAND_W-1]};
    assign w_diff = w_part - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // partial remainder always stays below the divisor
            n_rem = w_diff[RAND_W] ? w_part[RAND_W-1:0] : w_diff[RAND_W-1:0];
            n_dvd = {r_dvd[RAND_W-2:0], 1'b0};
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/rs_dpath.sv
// datapath: slot memory, item count, lfsr, rejection bound, divider and output register
module rs_dpath import rs_pkg::*; #(
    parameter int MAX_SLOTS  = 16,
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_rs_cmd                      i_cmd,
    output t_rs_sts                      o_sts,
    input  logic                         i_kind,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [VALUE_BITS-1:0] o_out_sample_value,
    output logic [IDX_W-1:0]             o_out_slot_index,
    output logic                         o_out_last
);

    logic [VALUE_BITS-1:0] r_mem [MAX_SLOTS];
    logic [VALUE_BITS-1:0] r_rd_data;

    logic [SIZE_W-1:0]     r_sample_size;
    logic [COUNT_W-1:0]    r_items_seen;
    logic [RAND_W-1:0]     r_rand;
    logic [RAND_W-1:0]     r_n;
    logic [RAND_W-1:0]     r_bound;
    logic [VALUE_BITS-1:0] r_value;
    logic [SIZE_W-1:0]     r_m;
    logic [SIZE_W-1:0]     r_cnt;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [IDX_W-1:0]      r_out_slot;
    logic                  r_out_last;

    logic [SIZE_W-1:0]     w_k;
    logic [COUNT_W-1:0]    w_items_next;
    logic [RAND_W-1:0]     w_n;
    logic [RAND_W-1:0]     w_rand_next;
    logic [RAND_W-1:0]     w_t;
    logic                  w_filling;
    logic [SIZE_W-1:0]     w_m;
    logic                  w_div_start;
    logic [RAND_W-1:0]     w_div_dvd;
    logic [RAND_W-1:0]     w_div_dsr;
    logic                  w_div_done;
    logic [RAND_W-1:0]     w_div_rem;
    logic                  w_hit;
    logic                  w_mem_we;
    logic [IDX_W-1:0]      w_mem_addr;
    logic [VALUE_BITS-1:0] w_mem_wdata;
    logic                  w_out_free;
    logic                  w_dump_last;

    // slots in use, clamped to 1..MAX_SLOTS
    always_comb begin
        if (r_sample_size == '0) begin
            w_k = SIZE_W'(1);
        end else if (int'(r_sample_size) > MAX_SLOTS) begin
            w_k = SIZE_W'(MAX_SLOTS);
        end else begin
            w_k = r_sample_size;
        end
    end

    assign w_items_next = (r_items_seen == COUNT_MAX) ? r_items_seen
                                                      : r_items_seen + COUNT_W'(1);
    assign w_n = (w_items_next > COUNT_W'(RAND_RANGE)) ? RAND_RANGE
                                                       : w_items_next[RAND_W-1:0];
    assign w_filling   = r_items_seen < COUNT_W'(w_k);
    assign w_m         = w_filling ? r_items_seen[SIZE_W-1:0] : w_k;
    assign w_rand_next = lfsr_next(r_rand);
    assign w_t         = w_rand_next - RAND_W'(1);

    assign w_div_start = i_cmd.div_start;
    assign w_div_dvd   = i_cmd.div_sel_t ? w_t : RAND_RANGE;
    assign w_div_dsr   = i_cmd.div_sel_t ? r_n : w_n;

    rs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // drawn slot lies inside the reservoir
    assign w_hit = w_div_rem < RAND_W'(w_k);

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = IDX_W'(r_items_seen);
        w_mem_wdata = i_value;
        if (i_cmd.offer && w_filling) begin
            w_mem_we = 1'b1;
        end else if (i_cmd.slot_write && w_hit) begin
            w_mem_we    = 1'b1;
            w_mem_addr  = IDX_W'(w_div_rem);
            w_mem_wdata = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[IDX_W'(r_cnt)];
    end

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_dump_last = (r_cnt + SIZE_W'(1)) == r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_size <= SIZE_RESET;
            r_items_seen  <= '0;
            r_rand        <= SEED_RESET;
            r_m           <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.cfg_write) begin
                unique case (i_cfg_index)
                    REG_SAMPLE_SIZE: r_sample_size <= i_cfg_data[SIZE_W-1:0];
                    REG_RANDOM_SEED: r_rand <= (i_cfg_data[RAND_W-1:0] == '0) ?
                                               SEED_RESET : i_cfg_data[RAND_W-1:0];
                    default: ;
                endcase
            end else if (i_cmd.draw_step) begin
                r_rand <= w_rand_next;
            end
            if (i_cmd.offer) begin
                r_items_seen <= w_items_next;
            end else if (i_cmd.dump_start) begin
                r_items_seen <= '0;
                r_m          <= w_m;
                r_cnt        <= '0;
            end
            if (i_cmd.dump_emit) begin
                r_cnt       <= r_cnt + SIZE_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.offer) begin
            r_value <= i_value;
            r_n     <= w_n;
        end
        if (i_cmd.bound_load) begin
            r_bound <= RAND_RANGE - w_div_rem;
        end
        if (i_cmd.dump_emit) begin
            r_out_value <= r_rd_data;
            r_out_slot  <= IDX_W'(r_cnt);
            r_out_last  <= w_dump_last;
        end
    end

    always_comb begin
        o_sts.in_dump    = i_kind;
        o_sts.dump_empty = r_items_seen == '0;
        o_sts.filling    = w_filling;
        o_sts.div_done   = w_div_done;
        o_sts.t_ok       = w_t < r_bound;
        o_sts.out_free   = w_out_free;
        o_sts.dump_last  = w_dump_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_sample_value = r_out_value;
    assign o_out_slot_index   = r_out_slot;
    assign o_out_last         = r_out_last;

endmodule

FILE: rtl/core/rs_ctrl.sv
// controller state machine: item intake, draw sequence and dump sequence
module rs_ctrl import rs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  t_rs_sts i_sts,
    output t_rs_cmd o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_BOUND = 3'd1;
    localparam logic [2:0] S_STEP      = 3'd2;
    localparam logic [2:0] S_DIV_T     = 3'd3;
    localparam logic [2:0] S_DUMP_RD   = 3'd4;
    localparam logic [2:0] S_DUMP_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       w_idle;

    assign w_idle      = r_state == S_IDLE;
    assign o_in_ready  = w_idle;
    assign o_cfg_ready = w_idle;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.cfg_write = i_cfg_valid && w_idle;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_dump) begin
                        o_cmd.dump_start = 1'b1;
                        n_state = i_sts.dump_empty ? S_IDLE : S_DUMP_RD;
                    end else begin
                        o_cmd.offer = 1'b1;
                        if (!i_sts.filling) begin
                            // reservoir full: work out the rejection bound first
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV_BOUND;
                        end
                    end
                end
            end
            S_DIV_BOUND: begin
                if (i_sts.div_done) begin
                    o_cmd.bound_load = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.draw_step = 1'b1;
                if (i_sts.t_ok) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_t = 1'b1;
                    n_state = S_DIV_T;
                end
            end
            S_DIV_T: begin
                if (i_sts.div_done) begin
                    o_cmd.slot_write = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.dump_emit = 1'b1;
                    n_state = i_sts.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/reservoir_sampler.sv
// Reservoir sampler (algorithm R), top level
// Input words on i_in: kind 0 offers value to the sample, kind 1 dumps the
// reservoir and restarts the stream. Output words on o_out carry one filled
// slot each, in slot order, with last set on the final one; a dump of an
// empty stream gives no words. i_cfg writes sample_size (index 0) and
// random_seed (index 1, also reloads the lfsr); it is taken only while idle.
// Items are taken one at a time. An offer while the reservoir is filling
// is written straight to its slot. Past that, the offer is accepted, the
// 31-step bound division runs, the lfsr is stepped once per try until a
// draw passes the bound (rejection is rare unless the count nears 2^31),
// and the remainder division picks the slot; the shared one-bit-per-cycle
// divider does both divisions. A dump reads each slot through the
// registered slot memory read and loads it into the output register.
// A stalled receiver holds the output register and the dump waits; the next
// item is accepted as soon as the last word is in the output register.
// Reset (synchronous, active low) clears the count, sets sample_size to 16
// and the lfsr to 1; the slot memory is not cleared.
module reservoir_sampler import rs_pkg::*; #(
    parameter int MAX_SLOTS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rs_in_if.sink     i_in,
    rs_out_if.source  o_out,
    rs_cfg_if.sink    i_cfg
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    t_rs_cmd w_cmd;
    t_rs_sts w_sts;

    rs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rs_dpath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_kind             (i_in.kind),
        .i_value            (i_in.value),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_out_sample_value (o_out.sample_value),
        .o_out_slot_index   (o_out.slot_index),
        .o_out_last         (o_out.last)
    );

endmodule

FILE: tb/tb_reservoir_sampler.sv
// self-checking testbench for reservoir_sampler: directed and random streams checked against a predictor
`timescale 1ns / 100ps

module tb_reservoir_sampler;
    import rs_pkg::*;

    localparam int MAX_SLOTS       = 16;
    localparam int VALUE_BITS      = 32;
    localparam int IDX_W           = 4;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int SETTLE_CYCLES   = 150;
    localparam int LONG_HOLD       = 600;
    localparam int IDLE_LIMIT      = 4000;
    localparam int PRINT_CAP       = 60;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_DUMP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [COUNT_W-1:0] DRAW_RANGE = {1'b0, RAND_RANGE};

    typedef struct {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] value;
    } t_stream_word;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]             slot;
        logic                         last;
    } t_sample_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rs_in_if  #(.VALUE_BITS(VALUE_BITS))               in_if ();
    rs_out_if #(.VALUE_BITS(VALUE_BITS), .IDX_W(IDX_W)) out_if ();
    rs_cfg_if                                          cfg_if ();

    reservoir_sampler #(
        .MAX_SLOTS  (MAX_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    logic signed [VALUE_BITS-1:0] slot_mem [MAX_SLOTS];
    logic [COUNT_W-1:0]           stream_count;
    logic [RAND_W-1:0]            prng_state;
    logic [SIZE_W-1:0]            size_reg;

    t_stream_word stream_words[$];
    t_sample_word expected_words[$];

    int mismatches  = 0;
    int words_seen  = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int src_gap     = 0;
    int snk_stall   = 0;
    int calm_left   = 0;
    int idle_cycles = 0;
    logic src_calm  = 1'b0;
    logic snk_calm  = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    function automatic logic [RAND_W-1:0] prng_step(input logic [RAND_W-1:0] s);
        logic [RAND_W-1:0] nx;
        nx = {s[RAND_W-2:0], s[RAND_W-1] ^ s[RAND_W-4]};
        if (nx == '0) begin
            nx = SEED_RESET;
        end
        return nx;
    endfunction

    // uniform 1..n by rejection, one prng step per try
    function automatic logic [COUNT_W-1:0] draw_uniform(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] lim, bound, t;
        lim = n;
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > DRAW_RANGE) begin
            lim = DRAW_RANGE;
        end
        bound = (DRAW_RANGE / lim) * lim;
        do begin
            prng_state = prng_step(prng_state);
            t = {1'b0, prng_state} - 1;
        end while (t >= bound);
        return t % lim + 1;
    endfunction

    task automatic advance_reservoir(input logic kind, input logic signed [VALUE_BITS-1:0] v);
        logic [COUNT_W-1:0] k, m, prior, r;
        t_sample_word w;
        k = (size_reg == 0) ? 1 : (size_reg > MAX_SLOTS) ? MAX_SLOTS : size_reg;
        if (kind == KIND_DUMP) begin
            m = (stream_count < k) ? stream_count : k;
            for (int s = 0; s < m; s++) begin
                w.value = slot_mem[s];
                w.slot  = IDX_W'(s);
                w.last  = (s + 1 == m);
                expected_words.insert(expected_words.size(), w);
            end
            stream_count = '0;
        end else begin
            prior = stream_count;
            if (stream_count != COUNT_MAX) begin
                stream_count++;
            end
            if (prior < k) begin
                slot_mem[prior] = v;
            end else begin
                r = draw_uniform(stream_count);
                if (r <= k) begin
                    slot_mem[(r - 1) % MAX_SLOTS] = v;
                end
            end
        end
    endtask

    function automatic int gap_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            return 0;
        end else if (sel < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VALUE_BITS-1){1'b0}}};
            1:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(input logic kind, input logic signed [VALUE_BITS-1:0] v);
        t_stream_word it;
        it.kind  = kind;
        it.value = v;
        stream_words.insert(stream_words.size(), it);
    endtask

    // block is idle once every word is in and out, plus time for a pending draw
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (stream_words.size() != 0 || in_if.valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_SAMPLE_SIZE: size_reg = data[SIZE_W-1:0];
            REG_RANDOM_SEED: prng_state = (data[RAND_W-1:0] == '0) ? SEED_RESET
                                                                   : data[RAND_W-1:0];
            default: ;
        endcase
    endtask

    // input driver
    always @(posedge i_clk) begin : stream_driver
        t_stream_word it;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.kind  <= KIND_OFFER;
            in_if.value <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                advance_reservoir(in_if.kind, in_if.value);
            end
            if (!in_if.valid || in_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_if.valid <= 1'b0;
                end else if (stream_words.size() > 0) begin
                    it = stream_words.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.kind  <= it.kind;
                    in_if.value <= it.value;
                    src_gap = src_calm ? 0 : gap_length();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin : sample_sink
        t_sample_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word slot %0d value %0d last %0b",
                                              out_if.slot_index, out_if.sample_value,
                                              out_if.last));
                end else begin
                    want = expected_words.pop_front();
                    if (out_if.sample_value !== want.value) begin
                        report_mismatch($sformatf("sample_value %0d, expected %0d",
                                                  out_if.sample_value, want.value));
                    end
                    if (out_if.slot_index !== want.slot) begin
                        report_mismatch($sformatf("slot_index %0d, expected %0d",
                                                  out_if.slot_index, want.slot));
                    end
                    if (out_if.last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b on slot %0d",
                                                  out_if.last, want.last, want.slot));
                    end
                end
                words_seen++;
                // park mid-dump so the block backs up onto its input
                if (holds_done < 2 && words_seen >= (holds_done == 0 ? 30 : 150)
                    && !out_if.last) begin
                    hold_left = LONG_HOLD;
                    holds_done++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (snk_calm) begin
                out_if.ready <= 1'b1;
            end else if (snk_stall > 0) begin
                snk_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    snk_stall = gap_length();
                end
            end
        end
    end

    // stretches without idling on either side
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm_left = $urandom_range(100, 400);
            src_calm <= ($urandom_range(0, 3) == 0);
            snk_calm <= ($urandom_range(0, 3) == 0);
        end else begin
            calm_left--;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] data;
        logic [SIZE_W-1:0]     size_pick;
        int                    n, len, sel;

        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_SAMPLE_SIZE;
        cfg_if.data  = '0;

        for (int s = 0; s < MAX_SLOTS; s++) begin
            slot_mem[s] = '0;
        end
        stream_count = '0;
        prng_state   = SEED_RESET;
        size_reg     = SIZE_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty dump, short stream, then a full stream that writes every slot
        push_word(KIND_DUMP, '1);
        push_word(KIND_OFFER, {1'b1, {(VALUE_BITS-1){1'b0}}});
        push_word(KIND_OFFER, {1'b0, {(VALUE_BITS-1){1'b1}}});
        push_word(KIND_OFFER, '1);
        push_word(KIND_OFFER, '0);
        push_word(KIND_DUMP, 32'h1234_5678);
        for (int i = 0; i < MAX_SLOTS + 1; i++) begin
            push_word(KIND_OFFER, (i % 2) ? (32'h5555_5555 ^ i) : (32'hAAAA_AAAA ^ (i << 8)));
        end
        push_word(KIND_DUMP, '0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_quiet();
            case (ph)
                0:       size_pick = 5'd1;
                1:       size_pick = 5'd0;
                2:       size_pick = 5'd31;
                3:       size_pick = 5'd16;
                4:       size_pick = SIZE_W'($urandom_range(2, 15));
                5:       size_pick = SIZE_W'($urandom_range(17, 30));
                default: size_pick = SIZE_W'($urandom_range(1, 16));
            endcase
            data = CFG_DATA_W'($urandom);
            data[SIZE_W-1:0] = size_pick;
            write_reg(REG_SAMPLE_SIZE, data);
            if (ph < 3 || $urandom_range(0, 1) == 0) begin
                case (ph)
                    0:       data = RAND_RANGE;
                    1:       data = '0;
                    2:       data = SEED_RESET;
                    default: data = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_RANDOM_SEED, data);
            end
            if (ph % 3 == 1) begin
                write_reg((ph % 2) ? REG_SPARE_3 : REG_SPARE_2, CFG_DATA_W'($urandom));
            end

            // streams of random length, mostly closed by a dump
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                sel = $urandom_range(0, 9);
                len = (sel < 6) ? $urandom_range(1, 20)
                    : (sel < 8) ? $urandom_range(0, 3) : $urandom_range(25, 60);
                for (int i = 0; i < len; i++) begin
                    push_word(KIND_OFFER, pick_value());
                end
                n += len;
                if ($urandom_range(0, 9) < 8) begin
                    push_word(KIND_DUMP, pick_value());
                    n++;
                end
            end
        end

        wait_quiet();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
